/* rtl/quaternion_vector_rotation_assert.svh */
// Assertion macros for the quaternion vector rotation block.
// Included by the top level; no other dependencies.
`ifndef QUATERNION_VECTOR_ROTATION_ASSERT_SVH
`define QUATERNION_VECTOR_ROTATION_ASSERT_SVH

`ifndef SYNTH
// same-cycle implication
`define QVR_ASSERT_SAME(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("qvr assertion failed");
// next-cycle implication
`define QVR_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("qvr assertion failed");
`else
`define QVR_ASSERT_SAME(lbl, clk, rst, ante, cons)
`define QVR_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

/* rtl/qvr_pkg.sv */
// Types and constants for the quaternion vector rotation block.
// No dependencies.
`timescale 1ns / 1ps

package qvr_pkg;

  localparam int FRAC_BITS = 14;
  localparam int SHIFT     = 2 * FRAC_BITS;

  localparam int QW      = 16;           // quaternion component
  localparam int VW      = 16;           // input vector component
  localparam int PROD1_W = QW + VW;      // q * v
  localparam int P_W     = PROD1_W + 1;  // sum of three q * v terms
  localparam int PROD2_W = P_W + QW;     // p * q
  localparam int SUM_W   = PROD2_W + 2;  // four p * q terms plus rounding
  localparam int RW      = 18;           // result component

  localparam int NUM_STAGES = 5;

  localparam logic signed [QW-1:0] QUAT_W_RESET = QW'(1 << FRAC_BITS);

  localparam logic signed [RW-1:0] ROT_MAX = {1'b0, {(RW-1){1'b1}}};
  localparam logic signed [RW-1:0] ROT_MIN = {1'b1, {(RW-1){1'b0}}};

  localparam logic signed [SUM_W-1:0] SUM_MAX = SUM_W'(ROT_MAX);
  localparam logic signed [SUM_W-1:0] SUM_MIN = SUM_W'(ROT_MIN);
  localparam logic signed [SUM_W-1:0] ROUND_HALF = SUM_W'(64'sd1 << (SHIFT - 1));

  typedef enum logic [1:0] {
    REG_QUAT_X = 2'd0,
    REG_QUAT_Y = 2'd1,
    REG_QUAT_Z = 2'd2,
    REG_QUAT_W = 2'd3
  } qvr_reg_t;

  typedef struct packed {
    logic signed [QW-1:0] x;
    logic signed [QW-1:0] y;
    logic signed [QW-1:0] z;
    logic signed [QW-1:0] w;
  } qvr_quat_t;

  // per-stage load enables from the pipeline control
  typedef struct packed {
    logic [NUM_STAGES-1:0] en;
  } qvr_ctrl_t;

endpackage

/* rtl/qvr_vec_if.sv */
// Input vector channel: valid/ready plus three signed components.
// Depends on qvr_pkg.
`timescale 1ns / 1ps

interface qvr_vec_if;
  logic                            valid;
  logic                            ready;
  logic signed [qvr_pkg::VW-1:0]   vec_x;
  logic signed [qvr_pkg::VW-1:0]   vec_y;
  logic signed [qvr_pkg::VW-1:0]   vec_z;

  modport source (output valid, output vec_x, output vec_y, output vec_z, input ready);
  modport sink   (input valid, input vec_x, input vec_y, input vec_z, output ready);
endinterface

/* rtl/qvr_rot_if.sv */
// Result channel: valid/ready plus rotated components and clip flag.
// Depends on qvr_pkg.
`timescale 1ns / 1ps

interface qvr_rot_if;
  logic                            valid;
  logic                            ready;
  logic signed [qvr_pkg::RW-1:0]   rot_x;
  logic signed [qvr_pkg::RW-1:0]   rot_y;
  logic signed [qvr_pkg::RW-1:0]   rot_z;
  logic                            saturated;

  modport source (output valid, output rot_x, output rot_y, output rot_z,
                  output saturated, input ready);
  modport sink   (input valid, input rot_x, input rot_y, input rot_z,
                  input saturated, output ready);
endinterface

/* rtl/qvr_datapath.sv */
// Five-stage arithmetic pipeline: q*v products, p sums, p*q products,
// rounding sums, shift and saturate. Depends on qvr_pkg.
`timescale 1ns / 1ps

module qvr_datapath (
  input  logic                                clk,
  input  qvr_pkg::qvr_ctrl_t                  ctrl,
  input  qvr_pkg::qvr_quat_t                  quat,
  input  logic signed [qvr_pkg::VW-1:0]       vec_x,
  input  logic signed [qvr_pkg::VW-1:0]       vec_y,
  input  logic signed [qvr_pkg::VW-1:0]       vec_z,
  output logic signed [qvr_pkg::RW-1:0]       rot_x,
  output logic signed [qvr_pkg::RW-1:0]       rot_y,
  output logic signed [qvr_pkg::RW-1:0]       rot_z,
  output logic                                saturated
);

  // stage 1: q * v products
  logic signed [qvr_pkg::PROD1_W-1:0] m_yz, m_zy, m_wx, m_zx, m_xz, m_wy;
  logic signed [qvr_pkg::PROD1_W-1:0] m_xy, m_yx, m_wz, m_xx, m_yy, m_zz;

  always_ff @(posedge clk) begin
    if (ctrl.en[0]) begin
      m_yz <= quat.y * vec_z;
      m_zy <= quat.z * vec_y;
      m_wx <= quat.w * vec_x;
      m_zx <= quat.z * vec_x;
      m_xz <= quat.x * vec_z;
      m_wy <= quat.w * vec_y;
      m_xy <= quat.x * vec_y;
      m_yx <= quat.y * vec_x;
      m_wz <= quat.w * vec_z;
      m_xx <= quat.x * vec_x;
      m_yy <= quat.y * vec_y;
      m_zz <= quat.z * vec_z;
    end
  end

  // stage 2: p = q * (v, 0)
  logic signed [qvr_pkg::P_W-1:0] px, py, pz, pw;

  always_ff @(posedge clk) begin
    if (ctrl.en[1]) begin
      px <= qvr_pkg::P_W'(m_yz) - qvr_pkg::P_W'(m_zy) + qvr_pkg::P_W'(m_wx);
      py <= qvr_pkg::P_W'(m_zx) - qvr_pkg::P_W'(m_xz) + qvr_pkg::P_W'(m_wy);
      pz <= qvr_pkg::P_W'(m_xy) - qvr_pkg::P_W'(m_yx) + qvr_pkg::P_W'(m_wz);
      pw <= -(qvr_pkg::P_W'(m_xx) + qvr_pkg::P_W'(m_yy) + qvr_pkg::P_W'(m_zz));
    end
  end

  // stage 3: p * conj(q) products
  logic signed [qvr_pkg::PROD2_W-1:0] n_yz, n_zy, n_wx, n_xw;
  logic signed [qvr_pkg::PROD2_W-1:0] n_zx, n_xz, n_wy, n_yw;
  logic signed [qvr_pkg::PROD2_W-1:0] n_xy, n_yx, n_wz, n_zw;

  always_ff @(posedge clk) begin
    if (ctrl.en[2]) begin
      n_yz <= py * quat.z;
      n_zy <= pz * quat.y;
      n_wx <= pw * quat.x;
      n_xw <= px * quat.w;
      n_zx <= pz * quat.x;
      n_xz <= px * quat.z;
      n_wy <= pw * quat.y;
      n_yw <= py * quat.w;
      n_xy <= px * quat.y;
      n_yx <= py * quat.x;
      n_wz <= pw * quat.z;
      n_zw <= pz * quat.w;
    end
  end

  // stage 4: vector part plus half LSB of the output scale
  logic signed [qvr_pkg::SUM_W-1:0] sx, sy, sz;

  always_ff @(posedge clk) begin
    if (ctrl.en[3]) begin
      sx <= qvr_pkg::SUM_W'(n_zy) - qvr_pkg::SUM_W'(n_yz) - qvr_pkg::SUM_W'(n_wx)
            + qvr_pkg::SUM_W'(n_xw) + qvr_pkg::ROUND_HALF;
      sy <= qvr_pkg::SUM_W'(n_xz) - qvr_pkg::SUM_W'(n_zx) - qvr_pkg::SUM_W'(n_wy)
            + qvr_pkg::SUM_W'(n_yw) + qvr_pkg::ROUND_HALF;
      sz <= qvr_pkg::SUM_W'(n_yx) - qvr_pkg::SUM_W'(n_xy) - qvr_pkg::SUM_W'(n_wz)
            + qvr_pkg::SUM_W'(n_zw) + qvr_pkg::ROUND_HALF;
    end
  end

  // stage 5: floor shift, clip to output range
  logic signed [qvr_pkg::SUM_W-1:0] tx, ty, tz;
  logic signed [qvr_pkg::RW-1:0]    cx, cy, cz;
  logic                             clip_x, clip_y, clip_z;

  always_comb begin
    tx = sx >>> qvr_pkg::SHIFT;
    ty = sy >>> qvr_pkg::SHIFT;
    tz = sz >>> qvr_pkg::SHIFT;

    clip_x = (tx > qvr_pkg::SUM_MAX) || (tx < qvr_pkg::SUM_MIN);
    clip_y = (ty > qvr_pkg::SUM_MAX) || (ty < qvr_pkg::SUM_MIN);
    clip_z = (tz > qvr_pkg::SUM_MAX) || (tz < qvr_pkg::SUM_MIN);

    cx = clip_x ? (tx[qvr_pkg::SUM_W-1] ? qvr_pkg::ROT_MIN : qvr_pkg::ROT_MAX)
                : tx[qvr_pkg::RW-1:0];
    cy = clip_y ? (ty[qvr_pkg::SUM_W-1] ? qvr_pkg::ROT_MIN : qvr_pkg::ROT_MAX)
                : ty[qvr_pkg::RW-1:0];
    cz = clip_z ? (tz[qvr_pkg::SUM_W-1] ? qvr_pkg::ROT_MIN : qvr_pkg::ROT_MAX)
                : tz[qvr_pkg::RW-1:0];
  end

  always_ff @(posedge clk) begin
    if (ctrl.en[4]) begin
      rot_x     <= cx;
      rot_y     <= cy;
      rot_z     <= cz;
      saturated <= clip_x | clip_y | clip_z;
    end
  end

endmodule

/* rtl/quaternion_vector_rotation.sv */
// Quaternion vector rotation, top level: config registers, pipeline control.
// An accepted request moves through the stage registers to the result on rot.
// Throughput: one vector per cycle; each stage holds when the next is full
// and stalled, so a blocked output backs up stage by stage, no bubbles.
// Reset (rst, synchronous): clears all stage valid bits and loads the
// identity quaternion. Depends on qvr_pkg, the channel interfaces, qvr_datapath.
`timescale 1ns / 1ps

`include "quaternion_vector_rotation_assert.svh"

module quaternion_vector_rotation (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [1:0]                    cfg_index,
  input  logic [qvr_pkg::QW-1:0]        cfg_data,
  qvr_vec_if.sink                       vec,
  qvr_rot_if.source                     rot
);

  qvr_pkg::qvr_quat_t quat;

  always_ff @(posedge clk) begin
    if (rst) begin
      quat.x <= '0;
      quat.y <= '0;
      quat.z <= '0;
      quat.w <= qvr_pkg::QUAT_W_RESET;
    end else if (cfg_we) begin
      unique case (qvr_pkg::qvr_reg_t'(cfg_index))
        qvr_pkg::REG_QUAT_X: quat.x <= cfg_data;
        qvr_pkg::REG_QUAT_Y: quat.y <= cfg_data;
        qvr_pkg::REG_QUAT_Z: quat.z <= cfg_data;
        qvr_pkg::REG_QUAT_W: quat.w <= cfg_data;
        default: ;
      endcase
    end
  end

  // stage valid bits; a stage loads when empty or when the next one moves
  logic [qvr_pkg::NUM_STAGES-1:0] stage_valid;
  qvr_pkg::qvr_ctrl_t             ctrl;

  always_comb begin
    ctrl.en[qvr_pkg::NUM_STAGES-1] = !stage_valid[qvr_pkg::NUM_STAGES-1] || rot.ready;
    for (int k = qvr_pkg::NUM_STAGES - 2; k >= 0; k--) begin
      ctrl.en[k] = !stage_valid[k] || ctrl.en[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= '0;
    end else begin
      if (ctrl.en[0]) begin
        stage_valid[0] <= vec.valid;
      end
      for (int k = 1; k < qvr_pkg::NUM_STAGES; k++) begin
        if (ctrl.en[k]) begin
          stage_valid[k] <= stage_valid[k-1];
        end
      end
    end
  end

  assign vec.ready = ctrl.en[0];
  assign rot.valid = stage_valid[qvr_pkg::NUM_STAGES-1];

  qvr_datapath u_datapath (
    .clk       (clk),
    .ctrl      (ctrl),
    .quat      (quat),
    .vec_x     (vec.vec_x),
    .vec_y     (vec.vec_y),
    .vec_z     (vec.vec_z),
    .rot_x     (rot.rot_x),
    .rot_y     (rot.rot_y),
    .rot_z     (rot.rot_z),
    .saturated (rot.saturated)
  );

  logic in_acc, out_acc;
  assign in_acc  = vec.valid && vec.ready;
  assign out_acc = rot.valid && rot.ready;

  int occ;
  assign occ = $countones(stage_valid);

  logic at_limit;
  assign at_limit = rot.rot_x == qvr_pkg::ROT_MAX || rot.rot_x == qvr_pkg::ROT_MIN ||
                    rot.rot_y == qvr_pkg::ROT_MAX || rot.rot_y == qvr_pkg::ROT_MIN ||
                    rot.rot_z == qvr_pkg::ROT_MAX || rot.rot_z == qvr_pkg::ROT_MIN;

  // a full, stalled pipe must not take a request
  `QVR_ASSERT_SAME(a_full_stall_blocks, clk, rst, (&stage_valid) && !rot.ready, !vec.ready)
  // occupancy tracks requests in and results out
  `QVR_ASSERT_NEXT(a_occupancy, clk, rst, 1'b1, occ == $past(occ) + $past(in_acc) - $past(out_acc))
  // a clip flag only comes with a component at a range limit
  `QVR_ASSERT_SAME(a_sat_at_limit, clk, rst, rot.valid && rot.saturated, at_limit)

endmodule

/* sim/qvr_rotation_checker.sv */
// Checker for the quaternion vector rotation block: watches the config port and both
// channels, predicts each rotated vector and compares it field by field.
// Depends on qvr_pkg and the qvr_vec_if / qvr_rot_if interfaces.
`timescale 1ns / 1ps

module qvr_rotation_checker (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [1:0]             cfg_index,
  input  logic [qvr_pkg::QW-1:0] cfg_data,
  qvr_vec_if                     vec,
  qvr_rot_if                     rot,
  output int                     failures,
  output int                     outstanding,
  output int                     checked,
  output int                     clipped
);
  import qvr_pkg::*;

  typedef struct packed {
    logic signed [RW-1:0] x;
    logic signed [RW-1:0] y;
    logic signed [RW-1:0] z;
    logic                 sat;
  } rot_result_t;

  qvr_quat_t   quat;
  rot_result_t expected_rot[$];

  // round to nearest (ties up), then clip to the result width
  function automatic logic signed [RW-1:0] round_clip(input longint s, inout logic sat);
    longint r;
    r = (s + (longint'(1) <<< (SHIFT - 1))) >>> SHIFT;
    if (r > longint'(ROT_MAX)) begin
      r = longint'(ROT_MAX);
      sat = 1'b1;
    end else if (r < longint'(ROT_MIN)) begin
      r = longint'(ROT_MIN);
      sat = 1'b1;
    end
    return RW'(r);
  endfunction

  // q * (v,0) * conj(q), vector part
  function automatic rot_result_t rotate_by_quat(input qvr_quat_t q,
                                                 input logic signed [VW-1:0] vx,
                                                 input logic signed [VW-1:0] vy,
                                                 input logic signed [VW-1:0] vz);
    longint qx, qy, qz, qw, ax, ay, az, px, py, pz, pw, rx, ry, rz;
    rot_result_t res;
    logic sat;
    qx = q.x;
    qy = q.y;
    qz = q.z;
    qw = q.w;
    ax = vx;
    ay = vy;
    az = vz;
    px = qy * az - qz * ay + qw * ax;
    py = qz * ax - qx * az + qw * ay;
    pz = qx * ay - qy * ax + qw * az;
    pw = -(qx * ax + qy * ay + qz * az);
    rx = -py * qz + pz * qy - qx * pw + px * qw;
    ry = -pz * qx + px * qz - qy * pw + py * qw;
    rz = -px * qy + py * qx - qz * pw + pz * qw;
    sat = 1'b0;
    res.x = round_clip(rx, sat);
    res.y = round_clip(ry, sat);
    res.z = round_clip(rz, sat);
    res.sat = sat;
    return res;
  endfunction

  always @(posedge clk) begin
    rot_result_t want;
    if (rst) begin
      quat = '{x: '0, y: '0, z: '0, w: QUAT_W_RESET};
      expected_rot.delete();
      failures = 0;
      checked = 0;
      clipped = 0;
    end else begin
      // prediction uses the quaternion in force before any write at this edge
      if (vec.valid && vec.ready)
        expected_rot.push_back(rotate_by_quat(quat, vec.vec_x, vec.vec_y, vec.vec_z));
      if (rot.valid && rot.ready) begin
        if (expected_rot.size() == 0) begin
          $error("result with no request pending: rot_x %0d rot_y %0d rot_z %0d",
                 rot.rot_x, rot.rot_y, rot.rot_z);
          failures++;
        end else begin
          want = expected_rot.pop_front();
          checked++;
          if (want.sat) clipped++;
          if (rot.rot_x !== want.x) begin
            $error("rot_x expected %0d got %0d", want.x, rot.rot_x);
            failures++;
          end
          if (rot.rot_y !== want.y) begin
            $error("rot_y expected %0d got %0d", want.y, rot.rot_y);
            failures++;
          end
          if (rot.rot_z !== want.z) begin
            $error("rot_z expected %0d got %0d", want.z, rot.rot_z);
            failures++;
          end
          if (rot.saturated !== want.sat) begin
            $error("saturated expected %0b got %0b", want.sat, rot.saturated);
            failures++;
          end
        end
      end
      if (cfg_we) begin
        case (qvr_reg_t'(cfg_index))
          REG_QUAT_X: quat.x = cfg_data;
          REG_QUAT_Y: quat.y = cfg_data;
          REG_QUAT_Z: quat.z = cfg_data;
          REG_QUAT_W: quat.w = cfg_data;
          default: ;
        endcase
      end
    end
    outstanding = expected_rot.size();
  end

endmodule

/* sim/tb_quaternion_vector_rotation.sv */
// Testbench top for quaternion_vector_rotation: clock, reset, config writes and
// vector stimulus under several idling patterns; verdict from qvr_rotation_checker.
// Depends on qvr_pkg, the channel interfaces, the block and the checker.
`timescale 1ns / 1ps

module tb_quaternion_vector_rotation;
  import qvr_pkg::*;

  logic          clk;
  logic          rst;
  logic          cfg_we;
  logic [1:0]    cfg_index;
  logic [QW-1:0] cfg_data;

  int failures;
  int outstanding;
  int checked;
  int clipped;
  int send_idle_pct;
  int recv_stall_pct;
  int n_settings;

  qvr_vec_if vec_ch ();
  qvr_rot_if rot_ch ();

  quaternion_vector_rotation dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .vec       (vec_ch),
    .rot       (rot_ch)
  );

  qvr_rotation_checker u_rot_check (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .vec         (vec_ch),
    .rot         (rot_ch),
    .failures    (failures),
    .outstanding (outstanding),
    .checked     (checked),
    .clipped     (clipped)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("quaternion_vector_rotation test failed");
    $finish;
  end

  // receiver back-pressure
  always @(negedge clk)
    rot_ch.ready <= ($urandom_range(99) >= recv_stall_pct);

  task automatic set_idling(input int mode);
    case (mode % 4)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 64; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 64; end
      default: begin send_idle_pct = 15; recv_stall_pct = 15; end
    endcase
  endtask

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_vec(input logic signed [VW-1:0] x, input logic signed [VW-1:0] y,
                          input logic signed [VW-1:0] z);
    logic taken;
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      vec_ch.valid <= 1'b0;
      @(negedge clk);
    end
    vec_ch.valid <= 1'b1;
    vec_ch.vec_x <= x;
    vec_ch.vec_y <= y;
    vec_ch.vec_z <= z;
    taken = 1'b0;
    while (!taken) begin
      #1;
      taken = vec_ch.ready;
      @(negedge clk);
    end
  endtask

  // hold off requests until every pending result is back
  task automatic drain;
    vec_ch.valid <= 1'b0;
    do @(negedge clk); while (outstanding != 0);
  endtask

  task automatic write_quat(input qvr_quat_t q);
    cfg_we <= 1'b1;
    cfg_index <= REG_QUAT_X;
    cfg_data <= q.x;
    @(negedge clk);
    cfg_index <= REG_QUAT_Y;
    cfg_data <= q.y;
    @(negedge clk);
    cfg_index <= REG_QUAT_Z;
    cfg_data <= q.z;
    @(negedge clk);
    cfg_index <= REG_QUAT_W;
    cfg_data <= q.w;
    @(negedge clk);
    cfg_we <= 1'b0;
    n_settings++;
  endtask

  function automatic qvr_quat_t pick_quat(input int k);
    qvr_quat_t q;
    real a, b, c, d, n;
    case (k % 6)
      0: q = '{x: 16'sd32767, y: 16'sd32767, z: 16'sd32767, w: 16'sd32767};
      1: q = '{x: -16'sd32768, y: -16'sd32768, z: -16'sd32768, w: -16'sd32768};
      2: q = '{x: '0, y: '0, z: '0, w: '0};
      5: begin
        q.x = QW'($urandom);
        q.y = QW'($urandom);
        q.z = QW'($urandom);
        q.w = QW'($urandom);
      end
      default: begin
        // roughly unit length, so most results stay in range
        a = $itor($urandom_range(2000)) - 1000.0;
        b = $itor($urandom_range(2000)) - 1000.0;
        c = $itor($urandom_range(2000)) - 1000.0;
        d = $itor($urandom_range(2000)) - 1000.0;
        n = $sqrt(a * a + b * b + c * c + d * d);
        if (n < 1.0) begin
          d = 1000.0;
          n = 1000.0;
        end
        q.x = QW'($rtoi(a / n * 16384.0));
        q.y = QW'($rtoi(b / n * 16384.0));
        q.z = QW'($rtoi(c / n * 16384.0));
        q.w = QW'($rtoi(d / n * 16384.0));
      end
    endcase
    return q;
  endfunction

  function automatic logic signed [VW-1:0] random_comp;
    int pick;
    pick = $urandom_range(15);
    if (pick == 0) return 16'sd32767;
    if (pick == 1) return -16'sd32768;
    if (pick == 2) return VW'($urandom_range(7)) - 16'sd4;
    if (pick == 3) return VW'($urandom_range(511)) - 16'sd256;
    return VW'($urandom);
  endfunction

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = REG_QUAT_X;
    cfg_data = '0;
    vec_ch.valid = 1'b0;
    vec_ch.vec_x = '0;
    vec_ch.vec_y = '0;
    vec_ch.vec_z = '0;
    rot_ch.ready = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    n_settings = 1;
    repeat (4) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // identity after reset
    set_idling(0);
    send_vec(0, 0, 0);
    send_vec(32767, 32767, 32767);
    send_vec(-32768, -32768, -32768);
    send_vec(1, -1, 12345);
    send_vec(-32768, 32767, -1);
    drain;

    // w = 0.5 scales by 1/4: halves land on ties
    set_idling(3);
    write_quat('{x: '0, y: '0, z: '0, w: 16'sd8192});
    send_vec(2, -2, 6);
    send_vec(-6, 1, -1);
    send_vec(3, -3, 0);
    drain;

    // most negative quaternion, |q|^2 = 16: overflow
    set_idling(2);
    write_quat('{x: -16'sd32768, y: -16'sd32768, z: -16'sd32768, w: -16'sd32768});
    send_vec(32767, -32768, 1);
    send_vec(-32768, -32768, -32768);
    send_vec(1, 1, 1);
    drain;

    // 90 degrees about z
    set_idling(1);
    write_quat('{x: '0, y: '0, z: 16'sd11585, w: 16'sd11585});
    send_vec(16384, 0, 0);
    send_vec(0, -32768, 0);
    send_vec(100, 200, 300);
    drain;

    // non-unit, largest positive components
    set_idling(0);
    write_quat('{x: 16'sd32767, y: '0, z: '0, w: 16'sd32767});
    send_vec(32767, 32767, 32767);
    send_vec(-32768, 0, 1);
    drain;

    for (int p = 0; p < 16; p++) begin
      set_idling(p);
      write_quat(pick_quat(p + p / 6));
      for (int i = 0; i < 118; i++) begin
        if ($urandom_range(199) == 0) drain;
        send_vec(random_comp(), random_comp(), random_comp());
      end
      drain;
    end

    repeat (20) @(negedge clk);
    $display("checked %0d rotated vectors over %0d quaternion settings", checked, n_settings);
    $display("%0d results clipped, idling patterns: none, sender, receiver, both", clipped);
    if (failures == 0 && outstanding == 0) begin
      $display("quaternion_vector_rotation test passed");
    end else begin
      $display("quaternion_vector_rotation test failed");
    end
    $finish;
  end

endmodule
